FILE: sv/tama_pkg.sv
// Shared constants and types of the three-axis moving-average filter.
`default_nettype none

package tama_pkg;

    // Samples kept per axis in the averaging window
    localparam int WINDOW_DEPTH = 16;

    // Width of one rate sample or mean
    localparam int DATA_W = 24;
    // Ring index width
    localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    // Running sum width: never overflows for a full window
    localparam int SUM_W  = DATA_W + $clog2(WINDOW_DEPTH);
    // Divisor width: holds 1 .. WINDOW_DEPTH
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    // Width of the divide step counter
    localparam int STEP_W = $clog2(SUM_W);
    // Number of axes
    localparam int AXES   = 3;

    // Control from the sequencer to each serial divider
    typedef struct packed {
        logic load;   // take the sum, form its magnitude, clear remainder
        logic step;   // retire one quotient bit
    } t_div_ctl;

endpackage

`default_nettype wire

FILE: sv/tama_in_if.sv
// Sample channel: valid/ready handshake carrying one three-axis rate request.
`default_nettype none

interface tama_in_if import tama_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] rate_x;
    logic signed [DATA_W-1:0] rate_y;
    logic signed [DATA_W-1:0] rate_z;

    modport source (output valid, output rate_x, output rate_y, output rate_z,
                    input ready);
    modport sink   (input valid, input rate_x, input rate_y, input rate_z,
                    output ready);

endinterface

`default_nettype wire

FILE: sv/tama_out_if.sv
// Mean channel: valid/ready handshake carrying one three-axis mean request.
`default_nettype none

interface tama_out_if import tama_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] mean_x;
    logic signed [DATA_W-1:0] mean_y;
    logic signed [DATA_W-1:0] mean_z;

    modport source (output valid, output mean_x, output mean_y, output mean_z,
                    input ready);
    modport sink   (input valid, input mean_x, input mean_y, input mean_z,
                    output ready);

endinterface

`default_nettype wire

FILE: sv/tama_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tama_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: sv/tama_div.sv
// Bit-serial signed divider: running sum by sample count, truncating toward zero.
`default_nettype none

module tama_div import tama_pkg::*; (
    input  wire logic                     i_clk,
    input  wire t_div_ctl                 i_ctl,
    input  wire logic signed [SUM_W-1:0]  i_sum,
    input  wire logic [CNT_W-1:0]         i_count,
    output logic signed [DATA_W-1:0]      o_quot
);

    logic [SUM_W-1:0] r_dvd;    // dividend shifts out at top, quotient in at bottom
    logic [CNT_W-1:0] r_rem;
    logic             r_neg;

    logic [SUM_W-1:0] w_mag;
    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_diff;
    logic             w_ge;
    logic [SUM_W-1:0] w_sres;

    // Magnitude of the sum; the most negative value maps to its unsigned size
    assign w_mag = i_sum[SUM_W-1] ? (~i_sum + 1'b1) : i_sum;

    // One restoring step: bring down the next dividend bit, try subtracting
    assign w_trial = {r_rem, r_dvd[SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_count});
    assign w_diff  = w_trial - {1'b0, i_count};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dvd <= w_mag;
            r_rem <= '0;
            r_neg <= i_sum[SUM_W-1];
        end else if (i_ctl.step) begin
            r_dvd <= {r_dvd[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        end
    end

    // Restore the sign of the quotient; the mean always fits the field
    assign w_sres = r_neg ? (~r_dvd + 1'b1) : r_dvd;
    assign o_quot = signed'(w_sres[DATA_W-1:0]);

endmodule

`default_nettype wire

FILE: sv/three_axis_moving_average_core.sv
// Top level of the three-axis moving-average filter.
//
// Usage:
//   i_smp carries one request of three signed 24-bit rate samples (x, y, z).
//   o_avg carries one request of three signed 24-bit means, one per sample.
//   Each axis keeps a ring window of WINDOW_DEPTH samples and a running sum.
//   Until the window has filled, the mean divides by the samples seen so far;
//   afterwards by WINDOW_DEPTH. Division truncates toward zero.
// Timing:
//   One sample at a time. After a sample is taken, the sum is updated, the
//   dividers are loaded, the bit-serial divide runs (the three axes side by
//   side), and the mean is registered once the output register is free.
//   Only then does the filter return to idle and take the next sample.
// Reset (i_rst_n low, synchronous): sums, ring position and full flag clear;
//   window entries not yet written since reset count as zero.
// Stall: the mean waits in the output register; the next sample is still
//   taken and processed, and its mean waits in the dividers until the
//   output register frees up.
`default_nettype none

module three_axis_moving_average_core import tama_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tama_in_if.sink   i_smp,
    tama_out_if.source o_avg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [POS_W-1:0]         r_pos;
    logic                     r_full;
    logic [CNT_W-1:0]         r_count;
    logic [STEP_W-1:0]        r_bit;
    logic                     r_ovalid;
    logic signed [SUM_W-1:0]  r_sum  [AXES];
    logic signed [DATA_W-1:0] r_samp [AXES];
    logic signed [DATA_W-1:0] r_mean [AXES];

    logic signed [SUM_W-1:0]  n_sum  [AXES];
    logic [POS_W-1:0]         n_pos;
    logic                     n_full;
    logic [CNT_W-1:0]         n_count;

    logic                     w_wrap;
    logic [AXES*DATA_W-1:0]   w_rd;
    logic signed [DATA_W-1:0] w_old  [AXES];
    logic signed [DATA_W-1:0] w_quot [AXES];
    t_div_ctl                 w_ctl;

    // Window storage, all three axes in one word
    tama_ram #(
        .WIDTH (AXES * DATA_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_state == S_LOAD),
        .i_waddr (r_pos),
        .i_wdata ({r_samp[2], r_samp[1], r_samp[0]}),
        .i_raddr (r_pos),
        .o_rdata (w_rd)
    );

    // Oldest value leaving the window; unwritten entries count as zero
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_old[a] = r_full ? signed'(w_rd[a*DATA_W +: DATA_W]) : '0;
            n_sum[a] = r_sum[a] - SUM_W'(w_old[a]) + SUM_W'(r_samp[a]);
        end
    end

    // Ring advance and divisor for this sample
    assign w_wrap  = (r_pos == POS_W'(WINDOW_DEPTH - 1));
    assign n_pos   = w_wrap ? '0 : r_pos + 1'b1;
    assign n_full  = r_full | w_wrap;
    assign n_count = n_full ? CNT_W'(WINDOW_DEPTH) : CNT_W'(n_pos);

    // Divider control
    assign w_ctl.load = (r_state == S_PREP);
    assign w_ctl.step = (r_state == S_DIV);

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        tama_div u_div (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_sum   (r_sum[g]),
            .i_count (r_count),
            .o_quot  (w_quot[g])
        );
    end

    // Sequencer, filter state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_full   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            // Output valid: set as a mean is registered, cleared as it is taken
            if (r_state == S_DONE && (!r_ovalid || o_avg.ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_avg.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_smp.valid) begin
                        r_samp[0] <= i_smp.rate_x;
                        r_samp[1] <= i_smp.rate_y;
                        r_samp[2] <= i_smp.rate_z;
                        r_state   <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int a = 0; a < AXES; a++) begin
                        r_sum[a] <= n_sum[a];
                    end
                    r_pos   <= n_pos;
                    r_full  <= n_full;
                    r_count <= n_count;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_bit   <= STEP_W'(SUM_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit != '0) begin
                        r_bit <= r_bit - 1'b1;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_avg.ready) begin
                        for (int a = 0; a < AXES; a++) begin
                            r_mean[a] <= w_quot[a];
                        end
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Ports
    assign i_smp.ready  = (r_state == S_IDLE);
    assign o_avg.valid  = r_ovalid;
    assign o_avg.mean_x = r_mean[0];
    assign o_avg.mean_y = r_mean[1];
    assign o_avg.mean_z = r_mean[2];

`ifndef SYNTHESIS
    // Divisor is never zero and never above the window depth while dividing
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count != '0 && r_count <= CNT_W'(WINDOW_DEPTH)))
        else $error("divisor out of range during divide");

    // Before the window fills, the divisor equals the ring position
    a_count_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !r_full) |-> (r_count == CNT_W'(r_pos)))
        else $error("divisor does not match samples seen");

    // Once full, the window stays full until reset
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("window full flag dropped");
`endif

endmodule

`default_nettype wire
